[rtl/cjw_pkg.sv]
package cjw_pkg;

    localparam int WORD_W    = 32;
    localparam int NUM_LANES = 10;
    localparam int NUM_ROWS  = 10;
    localparam int ROW_W     = 4;
    localparam int COL_W     = 4;
    localparam int CNT_W     = 4;
    localparam int KIND_W    = 3;
    localparam int IN_DATA_W  = WORD_W * NUM_LANES;
    localparam int OUT_DATA_W = ((CNT_W + WORD_W * NUM_LANES + 7) / 8) * 8;

    localparam logic [WORD_W-1:0] SPACES  = 32'h2020_2020;
    localparam logic [WORD_W-1:0] TAG_AMJ = 32'h2441_4D4A;
    localparam logic [WORD_W-1:0] TAG_DTA = 32'h2444_5441;
    localparam logic [WORD_W-1:0] TAG_END = 32'h2445_4E44;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_L    = 8'h4C;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_R    = 8'h52;
    localparam logic [7:0] CH_B    = 8'h42;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_H    = 8'h48;

    typedef enum logic [KIND_W-1:0] {
        KIND_OK     = 3'd0,
        KIND_PRINT  = 3'd1,
        KIND_HALT   = 3'd2,
        KIND_WAIT   = 3'd3,
        KIND_ADDR   = 3'd4,
        KIND_REJECT = 3'd5
    } kind_t;

    typedef struct packed {
        logic              we;
        logic [ROW_W-1:0]  row;
        logic [WORD_W-1:0] data;
    } lane_wr_t;

endpackage

[rtl/cjw_lane.sv]
module cjw_lane (
    input  logic                          clk,
    input  cjw_pkg::lane_wr_t             wr,
    input  logic [cjw_pkg::ROW_W-1:0]     rd_row,
    output logic [cjw_pkg::WORD_W-1:0]    rd_data
);

    logic [cjw_pkg::WORD_W-1:0] mem [cjw_pkg::NUM_ROWS];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.row] <= wr.data;
        end
        rd_data <= mem[rd_row];
    end

endmodule

[rtl/cjw_merge.sv]
module cjw_merge (
    input  logic [cjw_pkg::WORD_W-1:0] lane_data [cjw_pkg::NUM_LANES],
    input  logic [cjw_pkg::COL_W-1:0]  col,
    output logic [cjw_pkg::WORD_W-1:0] sel_word,
    output logic [cjw_pkg::WORD_W-1:0] line [cjw_pkg::NUM_LANES],
    output logic [cjw_pkg::CNT_W-1:0]  count
);

    logic [cjw_pkg::COL_W:0] idx [cjw_pkg::NUM_LANES];

    assign sel_word = lane_data[col];
    assign count    = cjw_pkg::CNT_W'(cjw_pkg::NUM_LANES) - col;

    always_comb
    begin
        for (int i = 0; i < cjw_pkg::NUM_LANES; i++)
        begin
            idx[i] = {1'b0, col} + (cjw_pkg::COL_W + 1)'(i);
            if (idx[i] < (cjw_pkg::COL_W + 1)'(cjw_pkg::NUM_LANES))
            begin
                line[i] = lane_data[idx[i][cjw_pkg::COL_W-1:0]];
            end
            else
            begin
                line[i] = '0;
            end
        end
    end

endmodule

[rtl/card_job_word_machine_unit.sv]
// Card job word machine. A beat on s_* with tuser 0 delivers a 40-character card, with
// tuser 1 executes one instruction; every beat yields exactly one result beat on m_*.
// The 100-word store is split into ten lanes of ten rows (word n sits in lane n mod 10,
// row n div 10), so a card or a print line moves through all lanes at once. A $AMJ card
// sweeps spaces through the ten rows before its result. A tick does a fetch read and a
// decode, plus a second read of the store when LR, CR or PD need one. The result may
// also wait on m_tready.
module card_job_word_machine_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // card_word_0 .. card_word_9
    input  logic [cjw_pkg::IN_DATA_W-1:0]     s_tdata,
    // opcode
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // line_count, line_word_0 .. line_word_9, zero pad
    output logic [cjw_pkg::OUT_DATA_W-1:0]    m_tdata,
    // result_kind
    output logic [cjw_pkg::KIND_W-1:0]        m_tuser
);

    localparam int NL = cjw_pkg::NUM_LANES;
    localparam int WW = cjw_pkg::WORD_W;
    localparam int RW = cjw_pkg::ROW_W;
    localparam int CW = cjw_pkg::COL_W;

    typedef enum logic [2:0] { S_IDLE, S_CLEAR, S_FETCH, S_EXEC, S_RESP } state_t;
    typedef enum logic [1:0] { M_LOAD, M_RUN, M_WAIT } mode_t;
    typedef enum logic [1:0] { OP_PD, OP_LR, OP_CR } op_t;

    state_t                 state_reg;
    mode_t                  mode_reg;
    op_t                    op_reg;
    logic [WW-1:0]          gw_reg;
    logic [RW-1:0]          ic_row_reg;
    logic [CW-1:0]          ic_col_reg;
    logic                   tog_reg;
    logic [RW-1:0]          lr_reg;
    logic [RW-1:0]          pa_row_reg;
    logic [CW-1:0]          pa_col_reg;
    logic [RW-1:0]          clr_row_reg;
    logic [CW-1:0]          col_sel_reg;
    cjw_pkg::kind_t         kind_reg;
    logic [cjw_pkg::CNT_W-1:0] cnt_reg;
    logic [WW-1:0]          line_reg [NL];
    logic                   m_tvalid_reg;
    logic [cjw_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic [cjw_pkg::KIND_W-1:0]     m_tuser_reg;

    logic [WW-1:0]          card [NL];
    cjw_pkg::lane_wr_t      lane_wr [NL];
    logic [RW-1:0]          rd_row;
    logic [WW-1:0]          lane_data [NL];
    logic [WW-1:0]          sel_word;
    logic [WW-1:0]          mline [NL];
    logic [cjw_pkg::CNT_W-1:0] mcount;
    logic                   accept;
    logic                   is_tag;

    logic [7:0]             c0, c1, ch2, ch3;
    logic                   dig_ok;
    logic [RW-1:0]          d2;
    logic [CW-1:0]          d3;
    logic                   is_instr;
    logic [CW:0]            gd_idx [NL];
    logic [cjw_pkg::OUT_DATA_W-1:0] out_pack;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign is_tag = (card[0] == cjw_pkg::TAG_AMJ) || (card[0] == cjw_pkg::TAG_DTA) ||
                    (card[0] == cjw_pkg::TAG_END);

    assign c0  = sel_word[31:24];
    assign c1  = sel_word[23:16];
    assign ch2 = sel_word[15:8];
    assign ch3 = sel_word[7:0];
    assign dig_ok = (ch2 >= cjw_pkg::CH_ZERO) && (ch2 <= cjw_pkg::CH_NINE) &&
                    (ch3 >= cjw_pkg::CH_ZERO) && (ch3 <= cjw_pkg::CH_NINE);
    assign d2 = RW'(ch2 - cjw_pkg::CH_ZERO);
    assign d3 = CW'(ch3 - cjw_pkg::CH_ZERO);
    assign is_instr = (((c0 == cjw_pkg::CH_G) || (c0 == cjw_pkg::CH_P)) &&
                       (c1 == cjw_pkg::CH_D)) ||
                      (((c0 == cjw_pkg::CH_L) || (c0 == cjw_pkg::CH_S) ||
                        (c0 == cjw_pkg::CH_C)) && (c1 == cjw_pkg::CH_R)) ||
                      ((c0 == cjw_pkg::CH_B) && (c1 == cjw_pkg::CH_T));

    assign rd_row = (state_reg == S_FETCH) ? d2 : ic_row_reg;

    always_comb
    begin
        for (int b = 0; b < NL; b++)
        begin
            card[b]   = s_tdata[WW*b +: WW];
            gd_idx[b] = CW'(b) - {1'b0, pa_col_reg};
            lane_wr[b].we   = 1'b0;
            lane_wr[b].row  = '0;
            lane_wr[b].data = '0;
        end
        for (int b = 0; b < NL; b++)
        begin
            if (accept && (s_tuser[0] == 1'b0) && (mode_reg == M_WAIT))
            begin
                lane_wr[b].we   = (CW'(b) >= pa_col_reg);
                lane_wr[b].row  = pa_row_reg;
                lane_wr[b].data = card[gd_idx[b][CW-1:0]];
            end
            else if (accept && (s_tuser[0] == 1'b0) && (mode_reg == M_LOAD) && !is_tag &&
                     (lr_reg < RW'(cjw_pkg::NUM_ROWS)))
            begin
                lane_wr[b].we   = 1'b1;
                lane_wr[b].row  = lr_reg;
                lane_wr[b].data = card[b];
            end
            else if (state_reg == S_CLEAR)
            begin
                lane_wr[b].we   = 1'b1;
                lane_wr[b].row  = clr_row_reg;
                lane_wr[b].data = cjw_pkg::SPACES;
            end
            else if ((state_reg == S_FETCH) && (c0 != cjw_pkg::CH_H) && is_instr && dig_ok &&
                     (c0 == cjw_pkg::CH_S) && (d3 == CW'(b)))
            begin
                lane_wr[b].we   = 1'b1;
                lane_wr[b].row  = d2;
                lane_wr[b].data = gw_reg;
            end
        end
    end

    generate
        for (genvar g = 0; g < NL; g++)
        begin : g_lane
            cjw_lane u_lane (
                .clk     (clk),
                .wr      (lane_wr[g]),
                .rd_row  (rd_row),
                .rd_data (lane_data[g])
            );
        end
    endgenerate

    cjw_merge u_merge (
        .lane_data (lane_data),
        .col       (col_sel_reg),
        .sel_word  (sel_word),
        .line      (mline),
        .count     (mcount)
    );

    always_comb
    begin
        out_pack = '0;
        if (kind_reg == cjw_pkg::KIND_PRINT)
        begin
            out_pack[cjw_pkg::CNT_W-1:0] = cnt_reg;
            for (int i = 0; i < NL; i++)
            begin
                out_pack[cjw_pkg::CNT_W + WW*i +: WW] = line_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC)
        begin
            line_reg <= mline;
            cnt_reg  <= mcount;
        end
        if ((state_reg == S_RESP) && (!m_tvalid_reg || m_tready))
        begin
            m_tdata_reg <= out_pack;
            m_tuser_reg <= kind_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mode_reg     <= M_LOAD;
            op_reg       <= OP_PD;
            gw_reg       <= cjw_pkg::SPACES;
            ic_row_reg   <= '0;
            ic_col_reg   <= '0;
            tog_reg      <= 1'b0;
            lr_reg       <= '0;
            pa_row_reg   <= '0;
            pa_col_reg   <= '0;
            clr_row_reg  <= '0;
            col_sel_reg  <= '0;
            kind_reg     <= cjw_pkg::KIND_OK;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && (s_tuser[0] == 1'b0))
                    begin
                        state_reg <= S_RESP;
                        kind_reg  <= cjw_pkg::KIND_OK;
                        if (mode_reg == M_WAIT)
                        begin
                            mode_reg <= M_RUN;
                        end
                        else if (mode_reg != M_LOAD)
                        begin
                            kind_reg <= cjw_pkg::KIND_REJECT;
                        end
                        else if (card[0] == cjw_pkg::TAG_AMJ)
                        begin
                            gw_reg      <= cjw_pkg::SPACES;
                            ic_row_reg  <= '0;
                            ic_col_reg  <= '0;
                            tog_reg     <= 1'b0;
                            clr_row_reg <= '0;
                            state_reg   <= S_CLEAR;
                        end
                        else if (card[0] == cjw_pkg::TAG_DTA)
                        begin
                            mode_reg <= M_RUN;
                        end
                        else if (card[0] == cjw_pkg::TAG_END)
                        begin
                            lr_reg <= '0;
                        end
                        else if (lr_reg >= RW'(cjw_pkg::NUM_ROWS))
                        begin
                            kind_reg <= cjw_pkg::KIND_REJECT;
                        end
                        else
                        begin
                            lr_reg <= lr_reg + 1'b1;
                        end
                    end
                    else if (accept)
                    begin
                        state_reg <= S_RESP;
                        if (mode_reg == M_WAIT)
                        begin
                            kind_reg <= cjw_pkg::KIND_WAIT;
                        end
                        else if (mode_reg != M_RUN)
                        begin
                            kind_reg <= cjw_pkg::KIND_REJECT;
                        end
                        else if (ic_row_reg >= RW'(cjw_pkg::NUM_ROWS))
                        begin
                            mode_reg <= M_LOAD;
                            kind_reg <= cjw_pkg::KIND_ADDR;
                        end
                        else
                        begin
                            col_sel_reg <= ic_col_reg;
                            state_reg   <= S_FETCH;
                        end
                    end
                end
                S_CLEAR:
                begin
                    clr_row_reg <= clr_row_reg + 1'b1;
                    if (clr_row_reg == RW'(cjw_pkg::NUM_ROWS - 1))
                    begin
                        state_reg <= S_RESP;
                    end
                end
                S_FETCH:
                begin
                    state_reg <= S_RESP;
                    kind_reg  <= cjw_pkg::KIND_OK;
                    if (ic_col_reg == CW'(NL - 1))
                    begin
                        ic_col_reg <= '0;
                        ic_row_reg <= ic_row_reg + 1'b1;
                    end
                    else
                    begin
                        ic_col_reg <= ic_col_reg + 1'b1;
                    end
                    if (c0 == cjw_pkg::CH_H)
                    begin
                        mode_reg <= M_LOAD;
                        kind_reg <= cjw_pkg::KIND_HALT;
                    end
                    else if (!is_instr)
                    begin
                        kind_reg <= cjw_pkg::KIND_OK;
                    end
                    else if (!dig_ok)
                    begin
                        mode_reg <= M_LOAD;
                        kind_reg <= cjw_pkg::KIND_ADDR;
                    end
                    else if (c0 == cjw_pkg::CH_G)
                    begin
                        pa_row_reg <= d2;
                        pa_col_reg <= d3;
                        mode_reg   <= M_WAIT;
                        kind_reg   <= cjw_pkg::KIND_WAIT;
                    end
                    else if (c0 == cjw_pkg::CH_B)
                    begin
                        if (tog_reg)
                        begin
                            ic_row_reg <= d2;
                            ic_col_reg <= d3;
                        end
                    end
                    else if (c0 != cjw_pkg::CH_S)
                    begin
                        col_sel_reg <= d3;
                        state_reg   <= S_EXEC;
                        if (c0 == cjw_pkg::CH_P)
                        begin
                            op_reg <= OP_PD;
                        end
                        else if (c0 == cjw_pkg::CH_L)
                        begin
                            op_reg <= OP_LR;
                        end
                        else
                        begin
                            op_reg <= OP_CR;
                        end
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_RESP;
                    kind_reg  <= cjw_pkg::KIND_OK;
                    unique case (op_reg)
                        OP_PD: kind_reg <= cjw_pkg::KIND_PRINT;
                        OP_LR: gw_reg   <= sel_word;
                        OP_CR: tog_reg  <= (sel_word == gw_reg);
                        default: kind_reg <= cjw_pkg::KIND_OK;
                    endcase
                end
                S_RESP:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/cjw_checker.sv]
module cjw_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [cjw_pkg::OUT_DATA_W-1:0]    m_tdata,
    input logic [cjw_pkg::KIND_W-1:0]        m_tuser
);

    // hold a stalled result beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped under stall");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= cjw_pkg::KIND_W'(cjw_pkg::KIND_REJECT)))
        else $error("result kind out of range");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != cjw_pkg::KIND_W'(cjw_pkg::KIND_PRINT))
        |-> (m_tdata == '0))
        else $error("non-print result carries line data");

    a_print: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == cjw_pkg::KIND_W'(cjw_pkg::KIND_PRINT))
        |-> (m_tdata[cjw_pkg::CNT_W-1:0] != '0) &&
            (m_tdata[cjw_pkg::CNT_W-1:0] <= cjw_pkg::CNT_W'(cjw_pkg::NUM_LANES)))
        else $error("print line count out of range");

    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat taken before result");

endmodule

bind card_job_word_machine_unit cjw_checker u_cjw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[tb/card_job_word_machine_unit_tb.sv]
module card_job_word_machine_unit_tb;
    import cjw_pkg::*;

    typedef enum logic [1:0] {
        LOADING  = 2'd0,
        RUNNING  = 2'd1,
        AWAITING = 2'd2
    } run_mode_t;

    typedef struct packed {
        logic                   op;
        logic [9:0][WORD_W-1:0] w;
    } card_beat_t;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [CNT_W-1:0]       cnt;
        logic [9:0][WORD_W-1:0] w;
    } line_beat_t;

    typedef struct packed {
        logic                   op;
        logic [9:0][WORD_W-1:0] w;
        logic                   fixed;
        logic [KIND_W-1:0]      kind;
    } dir_row_t;

    localparam logic OP_CARD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata;
    logic [0:0]              s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic [KIND_W-1:0]       m_tuser;

    card_job_word_machine_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    logic [WORD_W-1:0] mem [100];
    logic [WORD_W-1:0] gen_word;
    logic [6:0]        instr_ctr;
    logic              toggle;
    logic [6:0]        load_ptr;
    run_mode_t         mode;
    logic [6:0]        pend_addr;

    card_beat_t card_q [$];
    line_beat_t line_q [$];
    dir_row_t   rows   [$];
    int         send_idle;
    int         recv_idle;
    logic       hold;
    int         errors;
    int         pushed;

    always
    begin
        #5 clk = 1'b0;
        #5 clk = 1'b1;
    end

    initial
    begin
        #20_000_000;
        $display("card_job_word_machine_unit_tb: errors");
        $finish;
    end

    function automatic logic is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    task automatic predict_line(input card_beat_t it, output line_beat_t r);
        int a;
        int e;
        int i;
        logic [WORD_W-1:0] wd;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
        r = '0;
        if (it.op == OP_CARD)
        begin
            if (mode == AWAITING)
            begin
                a = pend_addr % 100;
                e = (a / 10 + 1) * 10;
                for (i = 0; a + i < e; i++)
                    mem[a + i] = it.w[i];
                mode = RUNNING;
                r.kind = KIND_OK;
            end
            else if (mode != LOADING)
                r.kind = KIND_REJECT;
            else if (it.w[0] == TAG_AMJ)
            begin
                for (i = 0; i < 100; i++)
                    mem[i] = SPACES;
                gen_word = SPACES;
                instr_ctr = '0;
                toggle = 1'b0;
                r.kind = KIND_OK;
            end
            else if (it.w[0] == TAG_DTA)
            begin
                mode = RUNNING;
                r.kind = KIND_OK;
            end
            else if (it.w[0] == TAG_END)
            begin
                load_ptr = '0;
                r.kind = KIND_OK;
            end
            else if (load_ptr >= 100)
                r.kind = KIND_REJECT;
            else
            begin
                for (i = 0; i < 10 && load_ptr + i < 100; i++)
                    mem[load_ptr + i] = it.w[i];
                load_ptr = (load_ptr + 10 > 100) ? 7'd100 : load_ptr + 7'd10;
                r.kind = KIND_OK;
            end
            return;
        end
        if (mode == AWAITING)
        begin
            r.kind = KIND_WAIT;
            return;
        end
        if (mode != RUNNING)
        begin
            r.kind = KIND_REJECT;
            return;
        end
        if (instr_ctr >= 100)
        begin
            mode = LOADING;
            r.kind = KIND_ADDR;
            return;
        end
        wd = mem[instr_ctr];
        instr_ctr = instr_ctr + 7'd1;
        {c0, c1, c2, c3} = wd;
        r.kind = KIND_OK;
        if (c0 == CH_H)
        begin
            mode = LOADING;
            r.kind = KIND_HALT;
            return;
        end
        if (!((c0 == CH_G || c0 == CH_P) && c1 == CH_D) &&
            !((c0 == CH_L || c0 == CH_S || c0 == CH_C) && c1 == CH_R) &&
            !(c0 == CH_B && c1 == CH_T))
            return;
        if (!is_digit(c2) || !is_digit(c3))
        begin
            mode = LOADING;
            r.kind = KIND_ADDR;
            return;
        end
        a = (c2 - CH_ZERO) * 10 + (c3 - CH_ZERO);
        case (c0)
            CH_G:
            begin
                pend_addr = 7'(a);
                mode = AWAITING;
                r.kind = KIND_WAIT;
            end
            CH_P:
            begin
                r.kind = KIND_PRINT;
                r.cnt = 4'(10 - a % 10);
                for (i = 0; i < r.cnt; i++)
                    r.w[i] = mem[a + i];
            end
            CH_L: gen_word = mem[a];
            CH_S: mem[a] = gen_word;
            CH_C: toggle = (mem[a] == gen_word);
            default:
                if (toggle)
                    instr_ctr = 7'(a);
        endcase
    endtask

    task automatic queue_beat(input card_beat_t it, input logic fixed,
                              input logic [KIND_W-1:0] kind);
        line_beat_t r;
        predict_line(it, r);
        if (fixed)
        begin
            r = '0;
            r.kind = kind;
        end
        line_q.push_back(r);
        card_q.push_back(it);
        pushed++;
    endtask

    function automatic logic [WORD_W-1:0] instr(logic [7:0] c0, logic [7:0] c1, int a);
        return {c0, c1, 8'(CH_ZERO + a / 10), 8'(CH_ZERO + a % 10)};
    endfunction

    function automatic logic [WORD_W-1:0] rand_instr(int pos);
        int r;
        int a;
        logic [7:0] junk;
        logic [WORD_W-1:0] w;
        r = $urandom_range(99);
        a = $urandom_range(99);
        if (r < 10)      w = instr(CH_G, CH_D, a);
        else if (r < 25) w = instr(CH_P, CH_D, a);
        else if (r < 40) w = instr(CH_L, CH_R, a);
        else if (r < 52) w = instr(CH_S, CH_R, a);
        else if (r < 67) w = instr(CH_C, CH_R, a);
        else if (r < 77) w = instr(CH_B, CH_T, (pos >= 99) ? 99 : $urandom_range(99, pos + 1));
        else if (r < 82) w = {CH_H, 24'($urandom())};
        else if (r < 92) w = $urandom();
        else
        begin
            w = instr(CH_L, CH_R, a);
            w[31:24] = (r[0]) ? CH_P : CH_C;
            junk = 8'($urandom());
            if (is_digit(junk))
                junk = 8'h78;
            if (r[1])
                w[15:8] = junk;
            else
                w[7:0] = junk;
        end
        return w;
    endfunction

    task automatic queue_card(input logic [WORD_W-1:0] w0);
        card_beat_t it;
        int i;
        it.op = OP_CARD;
        for (i = 0; i < 10; i++)
            it.w[i] = $urandom();
        it.w[0] = w0;
        queue_beat(it, 1'b0, KIND_OK);
    endtask

    task automatic queue_job();
        card_beat_t it;
        int ncards;
        int c;
        int i;
        int t;
        int base;
        if ($urandom_range(9) != 0)
            queue_card(TAG_AMJ);
        if ($urandom_range(4) == 0)
            queue_card(TAG_END);
        ncards = ($urandom_range(19) == 0) ? 11 : $urandom_range(1, 4);
        base = load_ptr;
        for (c = 0; c < ncards; c++)
        begin
            it.op = OP_CARD;
            for (i = 0; i < 10; i++)
                it.w[i] = rand_instr(base + c * 10 + i);
            queue_beat(it, 1'b0, KIND_OK);
        end
        if ($urandom_range(9) == 0)
            queue_card($urandom());
        queue_card(TAG_DTA);
        for (t = 0; t < 160 && mode != LOADING; t++)
        begin
            it.op = OP_TICK;
            for (i = 0; i < 10; i++)
                it.w[i] = $urandom();
            if (mode == AWAITING && $urandom_range(6) != 0)
            begin
                it.op = OP_CARD;
                if ($urandom_range(9) == 0)
                    it.w[0] = TAG_AMJ;
            end
            else if (mode == RUNNING && $urandom_range(19) == 0)
                it.op = OP_CARD;
            queue_beat(it, 1'b0, KIND_OK);
        end
    endtask

    task automatic drain();
        wait (line_q.size() == 0 && card_q.size() == 0);
        repeat (30) @(posedge clk);
    endtask

    function automatic dir_row_t row(logic op, logic [WORD_W-1:0] w0,
                                     logic [WORD_W-1:0] fill, logic fixed,
                                     logic [KIND_W-1:0] kind);
        dir_row_t d;
        int i;
        d.op = op;
        for (i = 0; i < 10; i++)
            d.w[i] = fill;
        d.w[0] = w0;
        d.fixed = fixed;
        d.kind = kind;
        return d;
    endfunction

    task automatic note_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
        errors++;
        if (errors <= 10)
            $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (card_q.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= card_q[0].w;
                s_tuser  <= card_q[0].op;
                card_q.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !hold && $urandom_range(99) >= recv_idle;
    end

    always @(posedge clk)
    begin
        line_beat_t want;
        int i;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (line_q.size() == 0)
                note_mismatch("unexpected beat", WORD_W'(m_tuser), '0);
            else
            begin
                want = line_q.pop_front();
                if (m_tuser !== want.kind)
                    note_mismatch("result_kind", WORD_W'(m_tuser), WORD_W'(want.kind));
                if (m_tdata[3:0] !== want.cnt)
                    note_mismatch("line_count", WORD_W'(m_tdata[3:0]), WORD_W'(want.cnt));
                for (i = 0; i < 10; i++)
                    if (m_tdata[4 + 32 * i +: 32] !== want.w[i])
                        note_mismatch($sformatf("line_word_%0d", i),
                                      m_tdata[4 + 32 * i +: 32], want.w[i]);
                if (m_tdata[OUT_DATA_W-1:324] !== '0)
                    note_mismatch("pad", WORD_W'(m_tdata[OUT_DATA_W-1:324]), '0);
            end
        end
    end

    initial
    begin
        card_beat_t it;
        int i;
        int k;
        for (i = 0; i < 100; i++)
            mem[i] = '0;
        gen_word = SPACES;
        instr_ctr = '0;
        toggle = 1'b0;
        load_ptr = '0;
        mode = LOADING;
        pend_addr = '0;
        errors = 0;
        pushed = 0;
        hold = 1'b0;
        send_idle = 19;
        recv_idle = 59;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        rows.push_back(row(OP_TICK, '1, '1, 1'b1, KIND_REJECT));
        rows.push_back(row(OP_CARD, TAG_END, '0, 1'b1, KIND_OK));
        rows.push_back(row(OP_CARD, TAG_AMJ, '1, 1'b1, KIND_OK));
        rows.push_back(row(OP_CARD, '1, '1, 1'b1, KIND_OK));
        rows.push_back(row(OP_CARD, '0, '0, 1'b1, KIND_OK));
        rows.push_back(row(OP_CARD, TAG_END, '1, 1'b1, KIND_OK));
        rows.push_back(row(OP_CARD, instr(CH_G, CH_D, 20), SPACES, 1'b0, KIND_OK));
        rows[$].w[1] = instr(CH_P, CH_D, 20);
        rows[$].w[2] = instr(CH_L, CH_R, 20);
        rows[$].w[3] = instr(CH_S, CH_R, 30);
        rows[$].w[4] = instr(CH_C, CH_R, 30);
        rows[$].w[5] = instr(CH_B, CH_T, 7);
        rows[$].w[6] = "XYZW";
        rows[$].w[7] = instr(CH_P, CH_D, 99);
        rows[$].w[8] = "LRa1";
        rows[$].w[9] = "H   ";
        rows.push_back(row(OP_CARD, TAG_DTA, '0, 1'b1, KIND_OK));
        rows.push_back(row(OP_TICK, '0, '0, 1'b1, KIND_WAIT));
        rows.push_back(row(OP_TICK, '1, '1, 1'b1, KIND_WAIT));
        rows.push_back(row(OP_CARD, TAG_AMJ, 32'h8000_0001, 1'b0, KIND_OK));
        rows.push_back(row(OP_CARD, TAG_DTA, '0, 1'b1, KIND_REJECT));
        for (k = 0; k < 6; k++)
            rows.push_back(row(OP_TICK, '0, '0, 1'b0, KIND_OK));
        rows.push_back(row(OP_TICK, '0, '0, 1'b1, KIND_ADDR));
        rows.push_back(row(OP_CARD, TAG_DTA, '0, 1'b1, KIND_OK));
        rows.push_back(row(OP_TICK, '0, '0, 1'b1, KIND_HALT));
        rows.push_back(row(OP_TICK, '0, '0, 1'b1, KIND_REJECT));
        foreach (rows[k])
        begin
            it.op = rows[k].op;
            it.w = rows[k].w;
            queue_beat(it, rows[k].fixed, rows[k].kind);
        end
        drain();

        for (k = 0; k < 3; k++)
        begin
            send_idle = (k == 0) ? 19 : (k == 1) ? 59 : 0;
            recv_idle = (k == 0) ? 59 : (k == 1) ? 19 : 0;
            pushed = 0;
            while (pushed < 500)
                queue_job();
            if (k == 2)
            begin
                @(posedge clk);
                hold <= 1'b1;
                repeat (400) @(posedge clk);
                hold <= 1'b0;
            end
            drain();
        end

        if (errors == 0)
            $display("card_job_word_machine_unit_tb: clean");
        else
            $display("card_job_word_machine_unit_tb: errors");
        $finish;
    end
endmodule

[files.f]
rtl/cjw_pkg.sv
rtl/cjw_lane.sv
rtl/cjw_merge.sv
rtl/card_job_word_machine_unit.sv
rtl/cjw_checker.sv
tb/card_job_word_machine_unit_tb.sv
